// File: rtl/ntoe_pkg.sv
// ----------------------------------------------------------------------------
// ntoe_pkg
// Shared types, codes and helpers of the remote-node table with oldest
// receive-time eviction.
// ----------------------------------------------------------------------------
package ntoe_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // Command codes
  localparam logic [2:0] CMD_COMMIT    = 3'd0;
  localparam logic [2:0] CMD_SELECT    = 3'd1;
  localparam logic [2:0] CMD_QUERY_ID  = 3'd2;
  localparam logic [2:0] CMD_QUERY_SEL = 3'd3;
  localparam logic [2:0] CMD_LIST      = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_UNKNOWN = 2'd2;

  // Node classes
  localparam logic [1:0] NODE_STALE      = 2'd0;
  localparam logic [1:0] NODE_ACTIVE     = 2'd1;
  localparam logic [1:0] NODE_DISCOVERED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_HB_STALE  = 2'd1;
  localparam logic [1:0] REG_DAT_STALE = 2'd2;

  localparam logic [31:0] HB_STALE_RST  = 32'd3000;
  localparam logic [31:0] DAT_STALE_RST = 32'd1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  node_id;
    logic [31:0] now_ms;
    logic [31:0] rx_time_ms;
    logic [31:0] heartbeat_time_ms;
    logic [31:0] data_time_ms;
    logic [3:0]  list_capacity;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_node_id;
    logic [31:0] sequence_res;
    logic [1:0]  node_state;
    logic [31:0] heartbeat_at_ms;
    logic [31:0] data_at_ms;
    logic        last_item;
  } rsp_item_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] hb;
    logic [31:0] dt;
    logic [31:0] seq;
  } slot_rec_t;

  // Classifies a node from its stored times, with wrapping ages.
  function automatic logic [1:0] classify(
    input logic [31:0] now,
    input logic [31:0] hb,
    input logic [31:0] dt,
    input logic [31:0] hb_thr,
    input logic [31:0] dt_thr
  );
    logic [31:0] hb_age;
    logic [31:0] dt_age;
    hb_age = now - hb;
    dt_age = now - dt;
    if (hb_age > hb_thr) begin
      return NODE_STALE;
    end else if (dt != 32'd0 && dt_age <= dt_thr) begin
      return NODE_ACTIVE;
    end
    return NODE_DISCOVERED;
  endfunction

endpackage

// File: rtl/ntoe_if.sv
// ----------------------------------------------------------------------------
// ntoe_req_if / ntoe_rsp_if
// Valid/ready channels that carry request and result transactions.
// ----------------------------------------------------------------------------
interface ntoe_req_if;
  logic                valid;
  logic                ready;
  ntoe_pkg::req_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ntoe_rsp_if;
  logic                valid;
  logic                ready;
  ntoe_pkg::rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ntoe_slot_ram.sv
// ----------------------------------------------------------------------------
// ntoe_slot_ram
// Single-write, single-read slot memory with a registered read port.
// ----------------------------------------------------------------------------
module ntoe_slot_ram #(
  parameter int DEPTH = ntoe_pkg::SLOT_COUNT_DEF,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  ntoe_pkg::slot_rec_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output ntoe_pkg::slot_rec_t rdata
);
  import ntoe_pkg::*;

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/node_table_oldest_eviction.sv
// ----------------------------------------------------------------------------
// node_table_oldest_eviction
// Commit, select or query: the result is loaded in the result state that follows
// acceptance, once the output register is free, and the next transaction is taken
// after the return to idle. An eviction commit scans every slot's receive time.
// A list gives one result per cycle while the output side takes them.
// Reset frees all slots at once; the slot memory itself is never cleared.
// ----------------------------------------------------------------------------
module node_table_oldest_eviction #(
  parameter int SLOT_COUNT = ntoe_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ntoe_req_if.sink    req,
  ntoe_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ntoe_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [3:0] LIST_MAX = 4'((SLOT_COUNT < 8) ? SLOT_COUNT : 8);

  // Controller states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CWR  = 3'd2;
  localparam logic [2:0] S_RSP  = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;
  localparam logic [2:0] S_FAIL = 3'd5;

  // Configuration registers, written over the APB port.
  logic [7:0]  own_id;
  logic [31:0] hb_thr;
  logic [31:0] dt_thr;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd0;
      hb_thr <= HB_STALE_RST;
      dt_thr <= DAT_STALE_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_OWN_ID:    own_id <= pwdata[7:0];
        REG_HB_STALE:  hb_thr <= pwdata;
        REG_DAT_STALE: dt_thr <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OWN_ID:    prdata = {24'd0, own_id};
      REG_HB_STALE:  prdata = hb_thr;
      REG_DAT_STALE: prdata = dt_thr;
      default:       prdata = 32'd0;
    endcase
  end

  // Slot owners live in flip-flops so that the id search is a single
  // parallel compare; an owner of zero marks a free slot. A bound slot has
  // always been written by a commit, so its memory record is meaningful.
  logic [7:0]      owner [SLOT_COUNT];
  logic [7:0]      selected;

  logic [2:0]      state;
  logic [7:0]      id;
  logic [31:0]     now;
  logic [31:0]     rx;
  logic [31:0]     hb;
  logic [31:0]     dt;
  logic [3:0]      cap;
  logic [3:0]      cnt;
  logic [SW-1:0]   slot;
  logic            fresh;
  logic [1:0]      fail_sts;
  logic [SW-1:0]   scan;
  logic [31:0]     best;
  logic [SW-1:0]   pick;

  logic            o_valid;
  rsp_item_t       o_item;
  logic            out_free;
  logic            load_out;

  logic            accept;
  logic [7:0]      key;
  logic            hit;
  logic [SW-1:0]   hit_idx;
  logic            free_any;
  logic [SW-1:0]   free_idx;
  logic            bound_any;
  logic [SW-1:0]   first_idx;
  logic            nxt_found;
  logic [SW-1:0]   nxt_idx;
  logic [3:0]      cap_sat;
  logic            list_last;
  logic [SW-1:0]   scan_pick;
  logic [31:0]     seq_new;

  logic            rd_en;
  logic [SW-1:0]   rd_addr;
  slot_rec_t       rd_data;
  logic            wr_en;
  slot_rec_t       wr_data;

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = o_valid;
  assign rsp.payload = o_item;

  // A result is loaded in every producing state once the output register
  // is free.
  assign load_out = out_free && (state == S_CWR || state == S_RSP ||
                                 state == S_FAIL || state == S_LIST);

  // The node being looked up: the request's id, or the selection for a query
  // of the selected node.
  assign key = (req.payload.command == CMD_QUERY_SEL) ? selected : req.payload.node_id;

  // Priority encoders: the descending loops leave the lowest index standing.
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    bound_any = 1'b0;
    first_idx = '0;
    nxt_found = 1'b0;
    nxt_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (key != 8'd0 && owner[i] == key) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (owner[i] == 8'd0) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end else begin
        bound_any = 1'b1;
        first_idx = SW'(i);
        if (i > int'(slot)) begin
          nxt_found = 1'b1;
          nxt_idx   = SW'(i);
        end
      end
    end
  end

  assign cap_sat   = (req.payload.list_capacity > LIST_MAX) ? LIST_MAX
                                                            : req.payload.list_capacity;
  assign list_last = (cnt + 4'd1 == cap) || !nxt_found;
  assign scan_pick = (rd_data.rx < best) ? scan : pick;
  assign seq_new   = fresh ? 32'd1 : rd_data.seq + 32'd1;

  // Memory read control: the record is requested ahead of use, as the read port is registered.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (req.payload.command == CMD_LIST) begin
            rd_addr = first_idx;
          end else if (req.payload.command == CMD_COMMIT && !hit && !free_any) begin
            rd_addr = '0;
          end else begin
            rd_addr = hit_idx;
          end
        end
      end
      S_SCAN: begin
        if (scan != LAST_SLOT) begin
          rd_en   = 1'b1;
          rd_addr = scan + SW'(1);
        end
      end
      S_LIST: begin
        if (out_free && !list_last) begin
          rd_en   = 1'b1;
          rd_addr = nxt_idx;
        end
      end
      default: ;
    endcase
  end

  assign wr_en   = (state == S_CWR) && out_free;
  assign wr_data = '{rx: rx, hb: hb, dt: dt, seq: seq_new};

  ntoe_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Control state and owners.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      o_valid  <= 1'b0;
      selected <= 8'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        owner[i] <= 8'd0;
      end
    end else begin
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.payload.command)
              CMD_COMMIT: begin
                if (req.payload.node_id == 8'd0 || req.payload.node_id == own_id) begin
                  state <= S_FAIL;
                end else if (hit || free_any) begin
                  state <= S_CWR;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_SELECT: begin
                if (req.payload.node_id == own_id || !hit) begin
                  state <= S_FAIL;
                end else begin
                  selected <= req.payload.node_id;
                  state    <= S_RSP;
                end
              end
              CMD_QUERY_ID, CMD_QUERY_SEL: begin
                state <= hit ? S_RSP : S_FAIL;
              end
              CMD_LIST: begin
                state <= (cap_sat != 4'd0 && bound_any) ? S_LIST : S_FAIL;
              end
              CMD_CLEAR: begin
                selected <= 8'd0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                  owner[i] <= 8'd0;
                end
                state <= S_FAIL;
              end
              default: state <= S_FAIL;
            endcase
          end
        end
        S_SCAN: begin
          if (scan == LAST_SLOT) begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          if (out_free) begin
            owner[slot] <= id;
            state       <= S_IDLE;
          end
        end
        S_RSP, S_FAIL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_LIST: begin
          if (out_free && list_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          id    <= key;
          now   <= req.payload.now_ms;
          rx    <= req.payload.rx_time_ms;
          hb    <= req.payload.heartbeat_time_ms;
          dt    <= req.payload.data_time_ms;
          cap   <= cap_sat;
          cnt   <= 4'd0;
          scan  <= '0;
          best  <= TIME_MAX;
          pick  <= '0;
          fresh <= !hit;
          slot  <= (req.payload.command == CMD_LIST) ? first_idx
                 : hit ? hit_idx : free_idx;
          case (req.payload.command)
            CMD_COMMIT, CMD_SELECT: fail_sts <= STS_INVALID;
            CMD_QUERY_ID, CMD_QUERY_SEL, CMD_LIST: fail_sts <= STS_UNKNOWN;
            CMD_CLEAR: fail_sts <= STS_OK;
            default: fail_sts <= STS_INVALID;
          endcase
        end
      end
      S_SCAN: begin
        best <= (rd_data.rx < best) ? rd_data.rx : best;
        pick <= scan_pick;
        if (scan == LAST_SLOT) begin
          slot <= scan_pick;
        end else begin
          scan <= scan + SW'(1);
        end
      end
      S_CWR: begin
        if (out_free) begin
          o_item <= '{status: STS_OK, result_node_id: id, sequence_res: seq_new,
                      node_state: classify(now, hb, dt, hb_thr, dt_thr),
                      heartbeat_at_ms: hb, data_at_ms: dt, last_item: 1'b1};
        end
      end
      S_RSP: begin
        if (out_free) begin
          o_item <= '{status: STS_OK, result_node_id: id, sequence_res: rd_data.seq,
                      node_state: classify(now, rd_data.hb, rd_data.dt, hb_thr, dt_thr),
                      heartbeat_at_ms: rd_data.hb, data_at_ms: rd_data.dt,
                      last_item: 1'b1};
        end
      end
      S_LIST: begin
        if (out_free) begin
          o_item <= '{status: STS_OK, result_node_id: owner[slot],
                      sequence_res: rd_data.seq,
                      node_state: classify(now, rd_data.hb, rd_data.dt, hb_thr, dt_thr),
                      heartbeat_at_ms: rd_data.hb, data_at_ms: rd_data.dt,
                      last_item: list_last};
          cnt  <= cnt + 4'd1;
          slot <= nxt_idx;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          o_item <= '{status: fail_sts, result_node_id: 8'd0, sequence_res: 32'd0,
                      node_state: NODE_STALE, heartbeat_at_ms: 32'd0,
                      data_at_ms: 32'd0, last_item: 1'b1};
        end
      end
      default: ;
    endcase
  end

endmodule
